// File: hw/rtl/ltlr_pkg.sv
// ----------------------------------------------------------------------------
// ltlr_pkg: shared types and constants of the LED drive-level regulator
// Item, result, configuration and state records, plus operation and register
// index codes.
// ----------------------------------------------------------------------------
package ltlr_pkg;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_SELECT = 1'b1
  } op_t;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_TEMP       = 3'd0,
    REG_LOW_VOLTAGE    = 3'd1,
    REG_SOLID_TOP      = 3'd2,
    REG_THERMAL_ENABLE = 3'd3,
    REG_VOLTAGE_ENABLE = 3'd4
  } reg_idx_t;

  localparam logic [7:0] MaxTempReset    = 8'd79;
  localparam logic [7:0] LowVoltageReset = 8'd125;
  localparam logic [7:0] SolidTopReset   = 8'd64;

  localparam logic [4:0] HotLimit   = 5'd16;
  localparam logic [4:0] HotTrip    = 5'd15;
  localparam logic [3:0] LowSatur   = 4'd15;
  localparam logic [3:0] LowTrip    = 4'd8;
  localparam logic [8:0] CoolMargin = 9'd2;

  typedef struct packed {
    op_t        operation;
    logic [7:0] level_request;
    logic [7:0] temperature;
    logic       voltage_ready;
    logic [7:0] voltage;
  } item_t;

  typedef struct packed {
    logic [7:0] drive_level;
    logic       shutdown;
    logic       battery_step;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [7:0]         data;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0] max_temp;
    logic [7:0] low_voltage;
    logic [7:0] solid_top;
    logic       thermal_enable;
    logic       voltage_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] cur_level;
    logic [7:0] requested_level;
    logic [4:0] hot_count;
    logic [3:0] low_count;
    logic       off_latched;
  } state_t;

endpackage

// File: hw/rtl/ltlr_stream_if.sv
// ----------------------------------------------------------------------------
// ltlr_stream_if: valid/ready channel
// Carries one payload per transfer; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface ltlr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/ltlr_step.sv
// ----------------------------------------------------------------------------
// ltlr_step: one regulator step
// Next state and result for one item: select, thermal regulation and
// low-battery step-down.
// ----------------------------------------------------------------------------
module ltlr_step (
  input  ltlr_pkg::cfg_t    cfg,
  input  ltlr_pkg::state_t  st,
  input  ltlr_pkg::item_t   item,
  output ltlr_pkg::state_t  st_next,
  output ltlr_pkg::result_t res
);
  import ltlr_pkg::*;

  logic [7:0] lvl_therm;
  logic [4:0] hot_inc;
  logic [4:0] hot_next;
  logic [3:0] low_next;
  logic       hot;
  logic       cool;
  logic       low;
  logic       stepped;
  logic       off_next;
  logic [7:0] lvl_final;

  always_comb begin
    st_next   = st;
    lvl_therm = st.cur_level;
    hot_next  = st.hot_count;
    low_next  = st.low_count;
    lvl_final = st.cur_level;
    off_next  = st.off_latched;
    stepped   = 1'b0;
    hot       = item.temperature >= cfg.max_temp;
    // cool: temperature below max_temp - 2, with no wrap when max_temp < 2
    cool      = ({1'b0, item.temperature} + CoolMargin) < {1'b0, cfg.max_temp};
    low       = item.voltage < cfg.low_voltage;
    hot_inc   = (st.hot_count < HotLimit) ? st.hot_count + 5'd1 : st.hot_count;

    if (!st.off_latched) begin
      unique case (item.operation)
        OP_SELECT: begin
          st_next.requested_level = item.level_request;
          st_next.cur_level       = item.level_request;
          st_next.hot_count       = '0;
          st_next.low_count       = '0;
        end
        OP_TICK: begin
          if (cfg.thermal_enable && (st.cur_level <= cfg.solid_top)) begin
            if (hot) begin
              hot_next = hot_inc;
              if ((hot_inc > HotTrip) && (st.cur_level > (cfg.solid_top >> 3))) begin
                lvl_therm = st.cur_level - 8'd1;
                hot_next  = '0;
              end
            end else begin
              hot_next = '0;
              if (cool && (st.cur_level < st.requested_level)) begin
                lvl_therm = st.cur_level + 8'd1;
              end
            end
          end
          lvl_final = lvl_therm;
          st_next.requested_level = st.requested_level;
          if (cfg.voltage_enable && item.voltage_ready) begin
            if (low) begin
              low_next = (st.low_count < LowSatur) ? st.low_count + 4'd1 : st.low_count;
            end else begin
              low_next = '0;
            end
            if (low_next >= LowTrip) begin
              priority if (lvl_therm > cfg.solid_top) begin
                lvl_final = cfg.solid_top >> 1;
              end else if (lvl_therm > 8'd1) begin
                lvl_final = (lvl_therm >> 2) + (lvl_therm >> 1);
              end else begin
                off_next = 1'b1;
              end
              st_next.requested_level = lvl_final;
              low_next = '0;
              stepped  = 1'b1;
            end
          end
          st_next.cur_level   = lvl_final;
          st_next.hot_count   = hot_next;
          st_next.low_count   = low_next;
          st_next.off_latched = off_next;
        end
        default: st_next = st;
      endcase
    end

    res.drive_level  = st_next.off_latched ? 8'd0 : st_next.cur_level;
    res.shutdown     = st_next.off_latched;
    res.battery_step = stepped;
  end

endmodule

// File: hw/rtl/led_thermal_lowbatt_regulator.sv
// Throughput: one item per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// The regulator state updates as an item moves into the result register.
// Reset (rst, synchronous): state, counters and shutdown latch clear, and the
// configuration returns to its defaults; the configuration port is always ready.
// ----------------------------------------------------------------------------
// led_thermal_lowbatt_regulator: LED drive-level regulator
// Thermal and low-battery step-down of the drive level, one result per item.
// ----------------------------------------------------------------------------
module led_thermal_lowbatt_regulator (
  input logic          clk,
  input logic          rst,
  ltlr_stream_if.sink   item,
  ltlr_stream_if.source result,
  ltlr_stream_if.sink   cfg
);
  import ltlr_pkg::*;

  cfg_t    cfg_q;
  state_t  st;
  state_t  st_next;
  item_t   item_q;
  logic    item_vld;
  result_t res_next;
  result_t res_q;
  logic    res_vld;
  logic    res_free;
  logic    advance;

  assign res_free   = !res_vld || result.ready;
  assign advance    = item_vld && res_free;
  assign item.ready = !item_vld || res_free;
  assign cfg.ready  = 1'b1;

  // configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.max_temp       <= MaxTempReset;
      cfg_q.low_voltage    <= LowVoltageReset;
      cfg_q.solid_top      <= SolidTopReset;
      cfg_q.thermal_enable <= 1'b1;
      cfg_q.voltage_enable <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.payload.index)
        REG_MAX_TEMP:       cfg_q.max_temp       <= cfg.payload.data;
        REG_LOW_VOLTAGE:    cfg_q.low_voltage    <= cfg.payload.data;
        REG_SOLID_TOP:      cfg_q.solid_top      <= cfg.payload.data;
        REG_THERMAL_ENABLE: cfg_q.thermal_enable <= cfg.payload.data[0];
        REG_VOLTAGE_ENABLE: cfg_q.voltage_enable <= cfg.payload.data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (item.ready) begin
      item_vld <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_q <= item.payload;
    end
  end

  ltlr_step u_step (
    .cfg     (cfg_q),
    .st      (st),
    .item    (item_q),
    .st_next (st_next),
    .res     (res_next)
  );

  // regulator state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= '0;
      res_vld <= 1'b0;
    end else begin
      if (advance) begin
        st <= st_next;
      end
      if (res_free) begin
        res_vld <= item_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign result.valid   = res_vld;
  assign result.payload = res_q;

  a_off_sticky: assert property (@(posedge clk) disable iff (rst)
    st.off_latched |=> st.off_latched)
    else $error("shutdown latch cleared without reset");

  a_hot_bound: assert property (@(posedge clk) disable iff (rst)
    st.hot_count <= HotLimit)
    else $error("hot count beyond saturation");

  a_low_bound: assert property (@(posedge clk) disable iff (rst)
    st.low_count < LowTrip)
    else $error("low count left at or above trip level");

  a_off_dark: assert property (@(posedge clk) disable iff (rst)
    (res_vld && res_q.shutdown) |-> (res_q.drive_level == 8'd0))
    else $error("drive level not zero after shutdown");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("state changed with no item moving");

endmodule

// File: verif/tb_led_thermal_lowbatt_regulator.sv
// ----------------------------------------------------------------------------
// tb_led_thermal_lowbatt_regulator: drive-level regulator testbench
// Runs a short directed sequence, then random select/tick streams under
// several register settings. Directed rows that carry an expected result are
// scored against it, all others against a cycle-free model of the regulator
// held in the testbench. Both channels idle at random, the result side is
// held off once for a long stretch, and the run closes by latching shutdown.
// ----------------------------------------------------------------------------
module tb_led_thermal_lowbatt_regulator;
  import ltlr_pkg::*;

  localparam int unsigned NumRegimes     = 6;
  localparam int unsigned ItemsPerRegime = 320;
  localparam int unsigned HoldOffCycles  = 200;
  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned StallLimit     = 1000;
  localparam int unsigned FirstUnusedReg = 5;
  localparam int unsigned LastUnusedReg  = 7;

  typedef struct {
    item_t       it;
    int unsigned reps;
    bit          typed;
    result_t     res;
  } step_row_t;

  logic clk;
  logic rst;

  ltlr_stream_if #(.payload_t(item_t))   item_ch ();
  ltlr_stream_if #(.payload_t(result_t)) result_ch ();
  ltlr_stream_if #(.payload_t(cfg_wr_t)) cfg_ch ();

  led_thermal_lowbatt_regulator dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  state_t      reg_state;
  cfg_t        reg_cfg;
  result_t     expected_drive_q [$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned steps_seen;
  int unsigned settings_seen;
  int unsigned send_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_asked;
  int unsigned hold_served;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One regulator step: a select, or thermal regulation then the battery check.
  function automatic void advance_regulator(inout state_t s, input cfg_t c,
                                            input item_t it, output result_t r);
    logic stepped;
    stepped = 1'b0;
    if (!s.off_latched) begin
      if (it.operation == OP_SELECT) begin
        s.requested_level = it.level_request;
        s.cur_level       = it.level_request;
        s.hot_count       = '0;
        s.low_count       = '0;
      end else begin
        if (c.thermal_enable && s.cur_level <= c.solid_top) begin
          if (it.temperature >= c.max_temp) begin
            if (s.hot_count < HotLimit) s.hot_count = s.hot_count + 5'd1;
            if (s.hot_count > HotTrip && s.cur_level > (c.solid_top >> 3)) begin
              s.cur_level = s.cur_level - 8'd1;
              s.hot_count = '0;
            end
          end else begin
            s.hot_count = '0;
            // cool margin without wrap: false whenever max_temp is below the margin
            if (({1'b0, it.temperature} + CoolMargin) < {1'b0, c.max_temp} &&
                s.cur_level < s.requested_level)
              s.cur_level = s.cur_level + 8'd1;
          end
        end
        if (c.voltage_enable && it.voltage_ready) begin
          if (it.voltage < c.low_voltage) begin
            if (s.low_count < LowSatur) s.low_count = s.low_count + 4'd1;
          end else begin
            s.low_count = '0;
          end
          if (s.low_count >= LowTrip) begin
            if (s.cur_level > c.solid_top)
              s.cur_level = c.solid_top >> 1;
            else if (s.cur_level > 8'd1)
              s.cur_level = (s.cur_level >> 2) + (s.cur_level >> 1);
            else
              s.off_latched = 1'b1;
            s.requested_level = s.cur_level;
            s.low_count       = '0;
            stepped           = 1'b1;
          end
        end
      end
    end
    r.drive_level  = s.off_latched ? 8'd0 : s.cur_level;
    r.shutdown     = s.off_latched;
    r.battery_step = stepped;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.operation     = op_t'($urandom_range(1));
    it.level_request = 8'($urandom_range(255));
    it.temperature   = 8'($urandom_range(255));
    it.voltage_ready = 1'($urandom_range(1));
    it.voltage       = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic step_row_t make_row(op_t op, logic [7:0] level, logic [7:0] temp,
                                         logic vready, logic [7:0] volt,
                                         int unsigned reps, bit typed, result_t res);
    step_row_t row;
    row.it.operation     = op;
    row.it.level_request = level;
    row.it.temperature   = temp;
    row.it.voltage_ready = vready;
    row.it.voltage       = volt;
    row.reps             = reps;
    row.typed            = typed;
    row.res              = res;
    return row;
  endfunction

  // Offer one item, hold it until the transfer, then log what it must produce.
  task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.payload <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    advance_regulator(reg_state, reg_cfg, it, res);
    expected_drive_q.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_drive_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Leaves valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_wr_t wr;
    wr.index = idx;
    wr.data  = data;
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= wr;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_MAX_TEMP:       reg_cfg.max_temp       = data;
      REG_LOW_VOLTAGE:    reg_cfg.low_voltage    = data;
      REG_SOLID_TOP:      reg_cfg.solid_top      = data;
      REG_THERMAL_ENABLE: reg_cfg.thermal_enable = data[0];
      REG_VOLTAGE_ENABLE: reg_cfg.voltage_enable = data[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input cfg_t c, input bit with_unused);
    int unsigned i;
    write_reg(REG_MAX_TEMP, c.max_temp);
    write_reg(REG_LOW_VOLTAGE, c.low_voltage);
    write_reg(REG_SOLID_TOP, c.solid_top);
    // junk in the upper bits of the one-bit registers must be dropped
    write_reg(REG_THERMAL_ENABLE, {7'($urandom_range(127)), c.thermal_enable});
    write_reg(REG_VOLTAGE_ENABLE, {7'($urandom_range(127)), c.voltage_enable});
    if (with_unused)
      for (i = FirstUnusedReg; i <= LastUnusedReg; i++)
        write_reg(CfgIdxW'(i), 8'($urandom_range(255)));
    cfg_ch.valid <= 1'b0;
    settings_seen++;
  endtask

  task automatic run_rows(input step_row_t rows [$]);
    foreach (rows[r])
      repeat (rows[r].reps) send_item(rows[r].it, rows[r].typed, rows[r].res);
  endtask

  // Segments of one select followed by a run of ticks with a thermal and a
  // battery flavour, sprinkled with fully random items.
  task automatic random_items(input int unsigned count, input bit hold_mid,
                              input bit drain_mid);
    int unsigned sent, run_len, thermal_mode, volt_mode, k;
    int mt, lv;
    item_t it;
    state_t peek;
    result_t unused_res;
    sent = 0;
    while (sent < count) begin
      mt = reg_cfg.max_temp;
      lv = reg_cfg.low_voltage;
      run_len = $urandom_range(40, 8);
      thermal_mode = $urandom_range(3);
      volt_mode = $urandom_range(2);
      for (k = 0; k <= run_len && sent < count; k++) begin
        it = random_item();
        if (k == 0) begin
          it.operation = OP_SELECT;
          if ($urandom_range(3) != 0)
            it.level_request = 8'($urandom_range(reg_cfg.solid_top, 0));
        end else if ($urandom_range(9) != 0) begin
          it.operation = OP_TICK;
          case (thermal_mode)
            0: it.temperature = 8'($urandom_range(255, mt));
            1: if (mt >= 3) it.temperature = 8'($urandom_range(mt - 3, 0));
            2: it.temperature = 8'($urandom_range(mt < 255 ? mt + 1 : 255, mt >= 3 ? mt - 3 : 0));
            default: ;
          endcase
          case (volt_mode)
            0: begin
              it.voltage_ready = ($urandom_range(9) != 0);
              if (lv > 0) it.voltage = 8'($urandom_range(lv - 1, 0));
            end
            1: it.voltage = 8'($urandom_range(255, lv));
            default: ;
          endcase
        end
        // keep the latch for the closing sequence
        peek = reg_state;
        advance_regulator(peek, reg_cfg, it, unused_res);
        if (peek.off_latched) it.voltage_ready = 1'b0;
        send_item(it, 1'b0, '0);
        sent++;
        if (sent == count / 2) begin
          if (hold_mid) hold_asked <= hold_asked + 1;
          if (drain_mid) drain_results();
        end
      end
    end
  endtask

  // Result side: random ready, plus one long hold-off on request.
  initial begin
    result_ch.ready = 1'b0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served++;
        result_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (result_ch.payload.battery_step) steps_seen++;
      if (expected_drive_q.size() == 0) begin
        $display("%0t: unexpected result, drive_level %0d shutdown %0b battery_step %0b",
                 $time, result_ch.payload.drive_level, result_ch.payload.shutdown,
                 result_ch.payload.battery_step);
        errors++;
      end else begin
        want = expected_drive_q.pop_front();
        if (result_ch.payload.drive_level !== want.drive_level) begin
          $display("%0t: drive_level expected %0d, got %0d", $time, want.drive_level,
                   result_ch.payload.drive_level);
          errors++;
        end
        if (result_ch.payload.shutdown !== want.shutdown) begin
          $display("%0t: shutdown expected %0b, got %0b", $time, want.shutdown,
                   result_ch.payload.shutdown);
          errors++;
        end
        if (result_ch.payload.battery_step !== want.battery_step) begin
          $display("%0t: battery_step expected %0b, got %0b", $time, want.battery_step,
                   result_ch.payload.battery_step);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_t        regimes [NumRegimes];
    cfg_t        defaults;
    step_row_t   opening_rows [$];
    step_row_t   closing_rows [$];
    int unsigned k;

    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.payload = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.payload  = '0;
    errors          = 0;
    items_sent      = 0;
    results_seen    = 0;
    steps_seen      = 0;
    settings_seen   = 0;
    hold_asked      = 0;
    quiet_cycles    = 0;

    defaults   = {MaxTempReset, LowVoltageReset, SolidTopReset, 1'b1, 1'b1};
    regimes[0] = defaults;
    regimes[1] = {8'd0, 8'd255, 8'd255, 1'b1, 1'b1};   // always hot, almost always low
    regimes[2] = {8'd255, 8'd0, 8'd1, 1'b1, 1'b1};     // never low, one solid level
    regimes[3] = {8'd2, 8'd200, 8'd128, 1'b1, 1'b0};   // cool rise impossible
    regimes[4] = {8'd1, 8'd130, 8'd8, 1'b0, 1'b1};
    regimes[5] = {8'd90, 8'd140, 8'd100, 1'b1, 1'b1};

    // Reset values apply throughout the opening rows.
    opening_rows.push_back(make_row(OP_TICK, 8'd0, 8'd0, 1'b0, 8'd0, 1, 1'b1,
                                    {8'd0, 1'b0, 1'b0}));
    opening_rows.push_back(make_row(OP_SELECT, 8'd255, 8'd0, 1'b0, 8'd0, 1, 1'b1,
                                    {8'd255, 1'b0, 1'b0}));
    // blinky level: no thermal action, eighth low sample halves the top solid level
    opening_rows.push_back(make_row(OP_TICK, 8'd0, 8'd255, 1'b1, 8'd0, 7, 1'b1,
                                    {8'd255, 1'b0, 1'b0}));
    opening_rows.push_back(make_row(OP_TICK, 8'd0, 8'd255, 1'b1, 8'd0, 1, 1'b1,
                                    {8'd32, 1'b0, 1'b1}));
    opening_rows.push_back(make_row(OP_SELECT, 8'd40, 8'd0, 1'b0, 8'd0, 1, 1'b1,
                                    {8'd40, 1'b0, 1'b0}));
    opening_rows.push_back(make_row(OP_TICK, 8'd0, 8'd255, 1'b1, 8'd255, 15, 1'b1,
                                    {8'd40, 1'b0, 1'b0}));
    // sixteenth hot tick, exactly at the threshold
    opening_rows.push_back(make_row(OP_TICK, 8'd0, 8'd79, 1'b0, 8'd0, 1, 1'b1,
                                    {8'd39, 1'b0, 1'b0}));
    opening_rows.push_back(make_row(OP_TICK, 8'd0, 8'd76, 1'b0, 8'd0, 1, 1'b1,
                                    {8'd40, 1'b0, 1'b0}));
    opening_rows.push_back(make_row(OP_TICK, 8'd0, 8'd77, 1'b1, 8'd124, 1, 1'b0, '0));

    // Lowest level with an exhausted battery: latch, then ignore everything.
    closing_rows.push_back(make_row(OP_SELECT, 8'd1, 8'd0, 1'b0, 8'd0, 1, 1'b1,
                                    {8'd1, 1'b0, 1'b0}));
    closing_rows.push_back(make_row(OP_TICK, 8'd0, 8'd78, 1'b1, 8'd0, 7, 1'b1,
                                    {8'd1, 1'b0, 1'b0}));
    closing_rows.push_back(make_row(OP_TICK, 8'd0, 8'd78, 1'b1, 8'd0, 1, 1'b1,
                                    {8'd0, 1'b1, 1'b1}));
    closing_rows.push_back(make_row(OP_SELECT, 8'd200, 8'd0, 1'b0, 8'd0, 1, 1'b1,
                                    {8'd0, 1'b1, 1'b0}));
    closing_rows.push_back(make_row(OP_TICK, 8'd0, 8'd255, 1'b1, 8'd0, 1, 1'b1,
                                    {8'd0, 1'b1, 1'b0}));

    reg_state     = '0;
    reg_cfg       = defaults;
    send_idle_pct = 14;
    sink_idle_pct = 71;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    run_rows(opening_rows);
    for (k = 0; k < NumRegimes; k++) begin
      if (k == 2) begin
        send_idle_pct = 71;
        sink_idle_pct = 14;
      end
      if (k == 4) begin
        send_idle_pct = 0;
        sink_idle_pct = 0;
      end
      drain_results();
      program_regs(regimes[k], k == 0);
      random_items(ItemsPerRegime, k == 4, k == 1);
    end
    drain_results();
    program_regs(defaults, 1'b0);
    run_rows(closing_rows);
    drain_results();

    $display("Run covered %0d items under %0d register settings besides the reset values,",
             items_sent, settings_seen);
    $display("with %0d results scored, %0d battery step-downs and the shutdown latch.",
             results_seen, steps_seen);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: led_thermal_lowbatt_regulator.f
hw/rtl/ltlr_pkg.sv
hw/rtl/ltlr_stream_if.sv
hw/rtl/ltlr_step.sv
hw/rtl/led_thermal_lowbatt_regulator.sv
verif/tb_led_thermal_lowbatt_regulator.sv
